>>> design/tcs_pkg.sv
// Shared types, constants and the solver micro-program for the touch calibration solver.
// Used by tcs_ctrl, tcs_datapath and touch_calibration_solver_top; depends on nothing.
`timescale 1ns / 1ps

package tcs_pkg;

  // Field and sum widths.
  localparam int RAW_W   = 12;
  localparam int SCR_W   = 11;
  localparam int SRX_W   = 15;
  localparam int SRXX_W  = 27;
  localparam int SSC_W   = 14;
  localparam int SSCR_W  = 26;
  localparam int CNT_W   = 3;
  localparam int OUT_W   = 32;
  localparam int IDX_W   = 3;

  // Serial multiply: signed 64-bit A times unsigned 27-bit B into a 128-bit accumulator.
  localparam int K_W       = 64;
  localparam int B_W       = 27;
  localparam int ACC_W     = 128;
  localparam int MUL_STEPS = B_W;
  localparam int DIV_STEPS = ACC_W;
  localparam int STEP_W    = 7;

  // Micro-program length and the result slots.
  localparam int PROG_LEN   = 33;
  localparam int PC_W       = 6;
  localparam logic [IDX_W-1:0] LAST_COEFF = 3'd5;
  localparam logic [IDX_W-1:0] SCALE_IDX  = 3'd6;

  // Operand sources for the multiply-accumulate unit, also used as store targets.
  typedef enum logic [4:0] {
    SRC_N, SRC_X, SRC_Y, SRC_X2, SRC_Y2, SRC_XY,
    SRC_KA, SRC_KB, SRC_KC, SRC_KE, SRC_KF, SRC_KI,
    SRC_SX, SRC_SXRX, SRC_SXRY, SRC_SY, SRC_SYRX, SRC_SYRY
  } src_t;

  // What happens when a multiply-accumulate finishes.
  typedef enum logic [1:0] {
    FIN_NONE, FIN_STORE, FIN_DET, FIN_DIV
  } fin_t;

  // Kind of result word loaded into the output register.
  typedef enum logic [1:0] {
    OUT_COEFF, OUT_SCALE, OUT_FAIL
  } out_kind_t;

  typedef struct packed {
    src_t a_sel;
    src_t b_sel;
    logic sub;
    logic clr;
    fin_t fin;
    src_t tgt;
  } uop_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accum;
    logic              clear;
    logic              mac_load;
    logic              mac_step;
    logic              store_k;
    logic              store_det;
    logic              div_start;
    logic              div_step;
    logic              out_load;
    out_kind_t         out_kind;
    logic [IDX_W-1:0]  out_index;
    logic              out_last;
    uop_t              uop;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pc_last;
    logic acc_zero;
  } dp_stat_t;

  function automatic uop_t mk(src_t a, src_t b, logic s, logic c, fin_t f, src_t t);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.sub   = s;
    u.clr   = c;
    u.fin   = f;
    u.tgt   = t;
    return u;
  endfunction

  // Micro-program: cofactors of the normal matrix, the determinant, then the
  // three-term numerator of each of the six coefficients.
  function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
    uop_t r;
    r = mk(SRC_N, SRC_N, 1'b0, 1'b1, FIN_NONE, SRC_N);
    case (pc)
      6'd0:  r = mk(SRC_X2, SRC_Y2,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd1:  r = mk(SRC_XY, SRC_XY,   1'b1, 1'b0, FIN_STORE, SRC_KA);
      6'd2:  r = mk(SRC_XY, SRC_Y,    1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd3:  r = mk(SRC_X,  SRC_Y2,   1'b1, 1'b0, FIN_STORE, SRC_KB);
      6'd4:  r = mk(SRC_X,  SRC_XY,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd5:  r = mk(SRC_Y,  SRC_X2,   1'b1, 1'b0, FIN_STORE, SRC_KC);
      6'd6:  r = mk(SRC_N,  SRC_Y2,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd7:  r = mk(SRC_Y,  SRC_Y,    1'b1, 1'b0, FIN_STORE, SRC_KE);
      6'd8:  r = mk(SRC_X,  SRC_Y,    1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd9:  r = mk(SRC_N,  SRC_XY,   1'b1, 1'b0, FIN_STORE, SRC_KF);
      6'd10: r = mk(SRC_N,  SRC_X2,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd11: r = mk(SRC_X,  SRC_X,    1'b1, 1'b0, FIN_STORE, SRC_KI);
      6'd12: r = mk(SRC_KA, SRC_N,    1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd13: r = mk(SRC_KB, SRC_X,    1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd14: r = mk(SRC_KC, SRC_Y,    1'b0, 1'b0, FIN_DET,   SRC_N);
      6'd15: r = mk(SRC_KA, SRC_SX,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd16: r = mk(SRC_KB, SRC_SXRX, 1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd17: r = mk(SRC_KC, SRC_SXRY, 1'b0, 1'b0, FIN_DIV,   SRC_N);
      6'd18: r = mk(SRC_KB, SRC_SX,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd19: r = mk(SRC_KE, SRC_SXRX, 1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd20: r = mk(SRC_KF, SRC_SXRY, 1'b0, 1'b0, FIN_DIV,   SRC_N);
      6'd21: r = mk(SRC_KC, SRC_SX,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd22: r = mk(SRC_KF, SRC_SXRX, 1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd23: r = mk(SRC_KI, SRC_SXRY, 1'b0, 1'b0, FIN_DIV,   SRC_N);
      6'd24: r = mk(SRC_KA, SRC_SY,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd25: r = mk(SRC_KB, SRC_SYRX, 1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd26: r = mk(SRC_KC, SRC_SYRY, 1'b0, 1'b0, FIN_DIV,   SRC_N);
      6'd27: r = mk(SRC_KB, SRC_SY,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd28: r = mk(SRC_KE, SRC_SYRX, 1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd29: r = mk(SRC_KF, SRC_SYRY, 1'b0, 1'b0, FIN_DIV,   SRC_N);
      6'd30: r = mk(SRC_KC, SRC_SY,   1'b0, 1'b1, FIN_NONE,  SRC_N);
      6'd31: r = mk(SRC_KF, SRC_SYRX, 1'b0, 1'b0, FIN_NONE,  SRC_N);
      6'd32: r = mk(SRC_KI, SRC_SYRY, 1'b0, 1'b0, FIN_DIV,   SRC_N);
      default: r = mk(SRC_N, SRC_N, 1'b0, 1'b1, FIN_NONE, SRC_N);
    endcase
    return r;
  endfunction

endpackage

>>> design/touch_calibration_solver_top.sv
// Top level of the touch calibration solver: controller plus datapath.
// Depends on tcs_pkg, tcs_ctrl and tcs_datapath.
`timescale 1ns / 1ps

// Each calibration point is one word on the input channel; no word comes out
// until the last point of a run. After the last point the block solves the
// 3x3 normal equations with one shared shift-add multiply-accumulate unit
// (33 products) and one restoring divider (one division per coefficient, six
// coefficients). It emits seven words (three screen x coefficients, three
// screen y coefficients, each as soon as it is divided, then the scale
// 2^FRAC_BITS), or one word with status set if the determinant is zero. New
// points are taken only while no run is solving.
module touch_calibration_solver_top #(
  parameter int NUM_POINTS = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tcs_pkg::RAW_W-1:0]         raw_x,
  input  logic [tcs_pkg::RAW_W-1:0]         raw_y,
  input  logic [tcs_pkg::SCR_W-1:0]         screen_x,
  input  logic [tcs_pkg::SCR_W-1:0]         screen_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tcs_pkg::OUT_W-1:0]  coeff_value,
  output logic [tcs_pkg::IDX_W-1:0]         coeff_index,
  output logic                              status,
  output logic                              last_of_run
);

  tcs_pkg::dp_cmd_t  cmd;
  tcs_pkg::dp_stat_t stat;

  // Sequencer.
  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic and storage.
  tcs_datapath #(
    .NUM_POINTS (NUM_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .raw_x       (raw_x),
    .raw_y       (raw_y),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .coeff_value (coeff_value),
    .coeff_index (coeff_index),
    .status      (status),
    .last_of_run (last_of_run)
  );

  // The block never takes a point while a result word is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result word is pending");

  // A failed solve is a single word, index zero, closing the run.
  a_fail_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (last_of_run && coeff_index == '0))
    else $error("failure word malformed");

  // The scale word closes a successful run.
  a_scale_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && coeff_index == tcs_pkg::SCALE_IDX) |->
      (last_of_run && !status && coeff_value == (tcs_pkg::OUT_W'(1) << FRAC_BITS)))
    else $error("scale word malformed");

  // After the closing word is taken the block is ready for a new run.
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=> in_ready)
    else $error("block not idle after end of run");

endmodule

>>> design/tcs_datapath.sv
// Datapath of the touch calibration solver: sums, serial multiply-accumulate,
// cofactor registers, serial divider and the output register. Depends on tcs_pkg.
`timescale 1ns / 1ps

module tcs_datapath #(
  parameter int NUM_POINTS = 5,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcs_pkg::dp_cmd_t              cmd,
  output tcs_pkg::dp_stat_t             stat,
  input  logic [tcs_pkg::RAW_W-1:0]     raw_x,
  input  logic [tcs_pkg::RAW_W-1:0]     raw_y,
  input  logic [tcs_pkg::SCR_W-1:0]     screen_x,
  input  logic [tcs_pkg::SCR_W-1:0]     screen_y,
  output logic signed [tcs_pkg::OUT_W-1:0] coeff_value,
  output logic [tcs_pkg::IDX_W-1:0]     coeff_index,
  output logic                          status,
  output logic                          last_of_run
);

  localparam int K_W   = tcs_pkg::K_W;
  localparam int ACC_W = tcs_pkg::ACC_W;
  localparam int B_W   = tcs_pkg::B_W;

  // Least-squares sums.
  logic [tcs_pkg::CNT_W-1:0]  point_count;
  logic [tcs_pkg::SRX_W-1:0]  sum_raw_x, sum_raw_y;
  logic [tcs_pkg::SRXX_W-1:0] sum_raw_xx, sum_raw_yy, sum_raw_xy;
  logic [tcs_pkg::SSC_W-1:0]  sum_scr_x, sum_scr_y;
  logic [tcs_pkg::SSCR_W-1:0] sum_scr_x_rx, sum_scr_x_ry, sum_scr_y_rx, sum_scr_y_ry;

  // Cofactors and determinant.
  logic signed [K_W-1:0] ka, kb, kc, ke, kf, ki, det;

  // Multiply-accumulate and divider registers.
  logic [ACC_W-1:0] acc, a_reg, numq;
  logic [B_W-1:0]   b_reg;
  logic [K_W-1:0]   rem, dvs;
  logic             neg;

  logic [2*tcs_pkg::RAW_W-1:0]             p_xx, p_yy, p_xy;
  logic [tcs_pkg::RAW_W+tcs_pkg::SCR_W-1:0] p_sxrx, p_sxry, p_syrx, p_syry;
  logic signed [K_W-1:0] a_val;
  logic [B_W-1:0]        b_val;
  logic [ACC_W-1:0]      a_ext, acc_mag;
  logic [K_W-1:0]        trial;
  logic                  fits;
  logic [tcs_pkg::OUT_W-1:0] sat_val;

  // Per-point products.
  assign p_xx   = raw_x * raw_x;
  assign p_yy   = raw_y * raw_y;
  assign p_xy   = raw_x * raw_y;
  assign p_sxrx = screen_x * raw_x;
  assign p_sxry = screen_x * raw_y;
  assign p_syrx = screen_y * raw_x;
  assign p_syry = screen_y * raw_y;

  // Operand selection for the multiply-accumulate unit.
  always_comb begin
    a_val = '0;
    unique case (cmd.uop.a_sel)
      tcs_pkg::SRC_N:  a_val = K_W'(NUM_POINTS);
      tcs_pkg::SRC_X:  a_val = K_W'(sum_raw_x);
      tcs_pkg::SRC_Y:  a_val = K_W'(sum_raw_y);
      tcs_pkg::SRC_X2: a_val = K_W'(sum_raw_xx);
      tcs_pkg::SRC_Y2: a_val = K_W'(sum_raw_yy);
      tcs_pkg::SRC_XY: a_val = K_W'(sum_raw_xy);
      tcs_pkg::SRC_KA: a_val = ka;
      tcs_pkg::SRC_KB: a_val = kb;
      tcs_pkg::SRC_KC: a_val = kc;
      tcs_pkg::SRC_KE: a_val = ke;
      tcs_pkg::SRC_KF: a_val = kf;
      tcs_pkg::SRC_KI: a_val = ki;
      default:         a_val = '0;
    endcase
    b_val = '0;
    unique case (cmd.uop.b_sel)
      tcs_pkg::SRC_N:    b_val = B_W'(NUM_POINTS);
      tcs_pkg::SRC_X:    b_val = B_W'(sum_raw_x);
      tcs_pkg::SRC_Y:    b_val = B_W'(sum_raw_y);
      tcs_pkg::SRC_X2:   b_val = sum_raw_xx;
      tcs_pkg::SRC_Y2:   b_val = sum_raw_yy;
      tcs_pkg::SRC_XY:   b_val = sum_raw_xy;
      tcs_pkg::SRC_SX:   b_val = B_W'(sum_scr_x);
      tcs_pkg::SRC_SXRX: b_val = B_W'(sum_scr_x_rx);
      tcs_pkg::SRC_SXRY: b_val = B_W'(sum_scr_x_ry);
      tcs_pkg::SRC_SY:   b_val = B_W'(sum_scr_y);
      tcs_pkg::SRC_SYRX: b_val = B_W'(sum_scr_y_rx);
      tcs_pkg::SRC_SYRY: b_val = B_W'(sum_scr_y_ry);
      default:           b_val = '0;
    endcase
  end

  assign a_ext   = {{(ACC_W-K_W){a_val[K_W-1]}}, a_val};
  assign acc_mag = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;

  // Restoring division trial: shift the next numerator bit into the remainder.
  assign trial = {rem[K_W-2:0], numq[ACC_W-1]};
  assign fits  = (trial >= dvs);

  // Saturate the quotient to 32-bit signed, with the sign applied.
  always_comb begin
    if (neg) begin
      if (numq[ACC_W-1:tcs_pkg::OUT_W] != '0 || numq[tcs_pkg::OUT_W-1:0] > 32'h8000_0000) begin
        sat_val = 32'h8000_0000;
      end else begin
        sat_val = ~numq[tcs_pkg::OUT_W-1:0] + 32'd1;
      end
    end else begin
      if (numq[ACC_W-1:tcs_pkg::OUT_W-1] != '0) begin
        sat_val = 32'h7FFF_FFFF;
      end else begin
        sat_val = numq[tcs_pkg::OUT_W-1:0];
      end
    end
  end

  assign stat.pc_last  = (point_count == tcs_pkg::CNT_W'(NUM_POINTS - 1));
  assign stat.acc_zero = (acc[K_W-1:0] == '0);

  // Sums and point count.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      point_count  <= '0;
      sum_raw_x    <= '0;
      sum_raw_y    <= '0;
      sum_raw_xx   <= '0;
      sum_raw_yy   <= '0;
      sum_raw_xy   <= '0;
      sum_scr_x    <= '0;
      sum_scr_y    <= '0;
      sum_scr_x_rx <= '0;
      sum_scr_x_ry <= '0;
      sum_scr_y_rx <= '0;
      sum_scr_y_ry <= '0;
    end else if (cmd.accum) begin
      point_count  <= point_count + tcs_pkg::CNT_W'(1);
      sum_raw_x    <= sum_raw_x + tcs_pkg::SRX_W'(raw_x);
      sum_raw_y    <= sum_raw_y + tcs_pkg::SRX_W'(raw_y);
      sum_raw_xx   <= sum_raw_xx + tcs_pkg::SRXX_W'(p_xx);
      sum_raw_yy   <= sum_raw_yy + tcs_pkg::SRXX_W'(p_yy);
      sum_raw_xy   <= sum_raw_xy + tcs_pkg::SRXX_W'(p_xy);
      sum_scr_x    <= sum_scr_x + tcs_pkg::SSC_W'(screen_x);
      sum_scr_y    <= sum_scr_y + tcs_pkg::SSC_W'(screen_y);
      sum_scr_x_rx <= sum_scr_x_rx + tcs_pkg::SSCR_W'(p_sxrx);
      sum_scr_x_ry <= sum_scr_x_ry + tcs_pkg::SSCR_W'(p_sxry);
      sum_scr_y_rx <= sum_scr_y_rx + tcs_pkg::SSCR_W'(p_syrx);
      sum_scr_y_ry <= sum_scr_y_ry + tcs_pkg::SSCR_W'(p_syry);
    end
  end

  // Serial shift-add multiply-accumulate and serial divider.
  always_ff @(posedge clk) begin
    if (cmd.mac_load) begin
      a_reg <= cmd.uop.sub ? (~a_ext + ACC_W'(1)) : a_ext;
      b_reg <= b_val;
      if (cmd.uop.clr) begin
        acc <= '0;
      end
    end else if (cmd.mac_step) begin
      if (b_reg[0]) begin
        acc <= acc + a_reg;
      end
      a_reg <= a_reg << 1;
      b_reg <= b_reg >> 1;
    end
    if (cmd.div_start) begin
      neg  <= acc[ACC_W-1] ^ det[K_W-1];
      numq <= acc_mag << FRAC_BITS;
      rem  <= '0;
      dvs  <= det[K_W-1] ? (~det + K_W'(1)) : det;
    end else if (cmd.div_step) begin
      rem  <= fits ? (trial - dvs) : trial;
      numq <= {numq[ACC_W-2:0], fits};
    end
  end

  // Cofactor and determinant storage.
  always_ff @(posedge clk) begin
    if (cmd.store_k) begin
      case (cmd.uop.tgt)
        tcs_pkg::SRC_KA: ka <= acc[K_W-1:0];
        tcs_pkg::SRC_KB: kb <= acc[K_W-1:0];
        tcs_pkg::SRC_KC: kc <= acc[K_W-1:0];
        tcs_pkg::SRC_KE: ke <= acc[K_W-1:0];
        tcs_pkg::SRC_KF: kf <= acc[K_W-1:0];
        tcs_pkg::SRC_KI: ki <= acc[K_W-1:0];
        default: ;
      endcase
    end
    if (cmd.store_det) begin
      det <= acc[K_W-1:0];
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      coeff_index <= cmd.out_index;
      last_of_run <= cmd.out_last;
      status      <= (cmd.out_kind == tcs_pkg::OUT_FAIL);
      unique case (cmd.out_kind)
        tcs_pkg::OUT_COEFF: coeff_value <= sat_val;
        tcs_pkg::OUT_SCALE: coeff_value <= tcs_pkg::OUT_W'(1) << FRAC_BITS;
        default:            coeff_value <= '0;
      endcase
    end
  end

endmodule

>>> design/tcs_ctrl.sv
// Controller of the touch calibration solver: steps through the micro-program,
// sequences multiply, divide and output words. Depends on tcs_pkg.
`timescale 1ns / 1ps

module tcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tcs_pkg::dp_cmd_t    cmd,
  input  tcs_pkg::dp_stat_t   stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_FIN, S_DIV, S_QUOT, S_EMIT
  } state_t;

  state_t                       state;
  logic [tcs_pkg::PC_W-1:0]     pc;
  logic [tcs_pkg::STEP_W-1:0]   cnt;
  logic [tcs_pkg::IDX_W-1:0]    coef;
  logic                         last;
  tcs_pkg::uop_t                uop;
  logic                         in_acc, out_acc;

  assign uop       = tcs_pkg::prog_rom(pc);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Command decode from the current state.
  always_comb begin
    cmd           = '0;
    cmd.uop       = uop;
    cmd.out_index = coef;
    cmd.out_kind  = tcs_pkg::OUT_COEFF;
    unique case (state)
      S_IDLE: cmd.accum = in_acc;
      S_LOAD: cmd.mac_load = 1'b1;
      S_MUL:  cmd.mac_step = 1'b1;
      S_FIN: begin
        cmd.store_k   = (uop.fin == tcs_pkg::FIN_STORE);
        cmd.store_det = (uop.fin == tcs_pkg::FIN_DET);
        cmd.div_start = (uop.fin == tcs_pkg::FIN_DIV);
        if (uop.fin == tcs_pkg::FIN_DET && stat.acc_zero) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = tcs_pkg::OUT_FAIL;
          cmd.out_index = '0;
          cmd.out_last  = 1'b1;
        end
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_QUOT: cmd.out_load = 1'b1;
      S_EMIT: begin
        if (out_acc && last) begin
          cmd.clear = 1'b1;
        end else if (out_acc && coef == tcs_pkg::LAST_COEFF) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = tcs_pkg::OUT_SCALE;
          cmd.out_index = tcs_pkg::SCALE_IDX;
          cmd.out_last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and sequencing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      cnt   <= '0;
      coef  <= '0;
      last  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && stat.pc_last) begin
            state <= S_LOAD;
            pc    <= '0;
            coef  <= '0;
            last  <= 1'b0;
          end
        end
        S_LOAD: begin
          state <= S_MUL;
          cnt   <= '0;
        end
        S_MUL: begin
          cnt <= cnt + tcs_pkg::STEP_W'(1);
          if (cnt == tcs_pkg::STEP_W'(tcs_pkg::MUL_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (uop.fin == tcs_pkg::FIN_DIV) begin
            state <= S_DIV;
            cnt   <= '0;
          end else if (uop.fin == tcs_pkg::FIN_DET && stat.acc_zero) begin
            state <= S_EMIT;
            last  <= 1'b1;
          end else begin
            state <= S_LOAD;
            pc    <= pc + tcs_pkg::PC_W'(1);
          end
        end
        S_DIV: begin
          cnt <= cnt + tcs_pkg::STEP_W'(1);
          if (cnt == tcs_pkg::STEP_W'(tcs_pkg::DIV_STEPS - 1)) begin
            state <= S_QUOT;
          end
        end
        S_QUOT: state <= S_EMIT;
        S_EMIT: begin
          if (out_acc) begin
            if (last) begin
              state <= S_IDLE;
            end else if (coef == tcs_pkg::LAST_COEFF) begin
              last <= 1'b1;
            end else begin
              coef  <= coef + tcs_pkg::IDX_W'(1);
              pc    <= pc + tcs_pkg::PC_W'(1);
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
